// ===== hw/rtl/pah_pkg.sv =====
// types and constants shared by the proximity alarm block
package pah_pkg;

  localparam logic OP_BEACON   = 1'b0;
  localparam logic OP_EVALUATE = 1'b1;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_TRACKED_SOURCE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTER_LEVEL      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXIT_LEVEL       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BEACON_TIMEOUT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HOLD         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DANGER_MIN       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_WEIGHT = 3'd6;

  localparam logic        [7:0]  RST_TRACKED_SOURCE   = 8'd2;
  localparam logic signed [7:0]  RST_ENTER_LEVEL      = -8'sd70;
  localparam logic signed [7:0]  RST_EXIT_LEVEL       = -8'sd78;
  localparam logic        [31:0] RST_BEACON_TIMEOUT   = 32'd3000;
  localparam logic        [31:0] RST_MIN_HOLD         = 32'd2000;
  localparam logic        [7:0]  RST_DANGER_MIN       = 8'd1;
  localparam logic        [8:0]  RST_SMOOTHING_WEIGHT = 9'd77;
  localparam logic        [8:0]  WEIGHT_ONE           = 9'd256;
  localparam logic signed [15:0] RST_SMOOTHED         = -16'sd25600;

  typedef struct packed {
    logic              operation;
    logic [7:0]        source_id;
    logic [7:0]        danger_in;
    logic signed [7:0] strength;
    logic [31:0]       now_ms;
  } in_item_t;

  typedef struct packed {
    logic       alarm_on;
    logic [7:0] alarm_source;
    logic [7:0] danger_out;
    logic       by_timeout;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          value;
  } cfg_write_t;

endpackage

// ===== hw/rtl/pah_if.sv =====
// valid/ready channel interfaces for items, results and register writes
interface pah_in_if;
  import pah_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pah_out_if;
  import pah_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pah_cfg_if;
  import pah_pkg::*;
  logic       valid;
  logic       ready;
  cfg_write_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/proximity_alarm_hysteresis_top.sv =====
// proximity alarm with smoothed strength and hysteresis, top level
//
//   channel   dir  handshake            payload
//   in_ch     in   valid/ready          operation, source_id, danger_in, strength, now_ms
//   out_ch    out  valid/ready          alarm_on, alarm_source, danger_out, by_timeout
//   cfg_ch    in   valid/ready (ready=1) index, value
//
// one item per cycle: an item is held in the input register, then the
// state and the result register update together
// the pipeline only stalls while a result waits in the output register
// rst_n is synchronous; config registers, state and valid flags return to their reset values
module proximity_alarm_hysteresis_top (
  input  logic       clk,
  input  logic       rst_n,
  pah_in_if.sink     in_ch,
  pah_out_if.source  out_ch,
  pah_cfg_if.sink    cfg_ch
);
  import pah_pkg::*;

  logic        [7:0]  tracked_r;
  logic signed [7:0]  enter_r;
  logic signed [7:0]  exit_r;
  logic        [31:0] timeout_r;
  logic        [31:0] hold_r;
  logic        [7:0]  danger_min_r;
  logic        [8:0]  weight_r;

  logic               seen_r,       seen_nxt;
  logic signed [15:0] smooth_r,     smooth_nxt;
  logic        [7:0]  last_dng_r,   last_dng_nxt;
  logic        [31:0] last_time_r,  last_time_nxt;
  logic               active_r,     active_nxt;
  logic        [31:0] start_r,      start_nxt;

  in_item_t           item_r,       item_nxt;
  logic               item_vld_r,   item_vld_nxt;
  out_item_t          res_r,        res_nxt;
  logic               res_vld_r,    res_vld_nxt;

  logic               adv;
  logic               in_xfer;
  logic        [8:0]  w_sat;
  logic signed [15:0] str_q;
  logic signed [16:0] diff;
  logic signed [26:0] prod;
  logic signed [15:0] ema;
  logic        [31:0] since_beacon;
  logic        [31:0] since_start;
  logic               held;
  logic               timed_out;
  logic               dangerous;
  logic               near;
  logic               far;

  // config registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tracked_r    <= RST_TRACKED_SOURCE;
      enter_r      <= RST_ENTER_LEVEL;
      exit_r       <= RST_EXIT_LEVEL;
      timeout_r    <= RST_BEACON_TIMEOUT;
      hold_r       <= RST_MIN_HOLD;
      danger_min_r <= RST_DANGER_MIN;
      weight_r     <= RST_SMOOTHING_WEIGHT;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.data.index)
        CFG_TRACKED_SOURCE:   tracked_r    <= cfg_ch.data.value[7:0];
        CFG_ENTER_LEVEL:      enter_r      <= cfg_ch.data.value[7:0];
        CFG_EXIT_LEVEL:       exit_r       <= cfg_ch.data.value[7:0];
        CFG_BEACON_TIMEOUT:   timeout_r    <= cfg_ch.data.value;
        CFG_MIN_HOLD:         hold_r       <= cfg_ch.data.value;
        CFG_DANGER_MIN:       danger_min_r <= cfg_ch.data.value[7:0];
        CFG_SMOOTHING_WEIGHT: weight_r     <= cfg_ch.data.value[8:0];
        default: ;
      endcase
    end
  end

  // handshakes
  assign adv          = item_vld_r && (!res_vld_r || out_ch.ready);
  assign in_ch.ready  = !item_vld_r || adv;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = res_vld_r;
  assign out_ch.data  = res_r;

  // smoothing: s + floor(w * (sample - s) / 256)
  assign w_sat = (weight_r > WEIGHT_ONE) ? WEIGHT_ONE : weight_r;
  assign str_q = {item_r.strength, 8'h00};
  assign diff  = {str_q[15], str_q} - {smooth_r[15], smooth_r};
  assign prod  = $signed({1'b0, w_sat}) * diff;
  assign ema   = smooth_r + prod[23:8];

  // alarm tests
  assign since_beacon = item_r.now_ms - last_time_r;
  assign since_start  = item_r.now_ms - start_r;
  assign held         = since_start >= hold_r;
  assign timed_out    = since_beacon > timeout_r;
  assign dangerous    = last_dng_r >= danger_min_r;
  assign near         = smooth_r >= $signed({enter_r, 8'h00});
  assign far          = smooth_r <= $signed({exit_r, 8'h00});

  always_comb begin
    seen_nxt      = seen_r;
    smooth_nxt    = smooth_r;
    last_dng_nxt  = last_dng_r;
    last_time_nxt = last_time_r;
    active_nxt    = active_r;
    start_nxt     = start_r;
    res_nxt       = res_r;
    res_vld_nxt   = res_vld_r && !out_ch.ready;
    item_nxt      = item_r;
    item_vld_nxt  = item_vld_r;

    if (adv) begin
      item_vld_nxt = 1'b0;
      if (item_r.operation == OP_BEACON) begin
        if (item_r.source_id == tracked_r) begin
          seen_nxt      = 1'b1;
          smooth_nxt    = seen_r ? ema : str_q;
          last_dng_nxt  = item_r.danger_in;
          last_time_nxt = item_r.now_ms;
        end
      end else if (seen_r) begin
        res_nxt.alarm_source = tracked_r;
        res_nxt.danger_out   = last_dng_r;
        if (timed_out) begin
          if (active_r && held) begin
            active_nxt         = 1'b0;
            res_vld_nxt        = 1'b1;
            res_nxt.alarm_on   = 1'b0;
            res_nxt.by_timeout = 1'b1;
          end
        end else if (!active_r) begin
          if (dangerous && near) begin
            active_nxt         = 1'b1;
            start_nxt          = item_r.now_ms;
            res_vld_nxt        = 1'b1;
            res_nxt.alarm_on   = 1'b1;
            res_nxt.by_timeout = 1'b0;
          end
        end else if (held && (far || !dangerous)) begin
          active_nxt         = 1'b0;
          res_vld_nxt        = 1'b1;
          res_nxt.alarm_on   = 1'b0;
          res_nxt.by_timeout = 1'b0;
        end
      end
    end

    if (in_xfer) begin
      item_vld_nxt = 1'b1;
      item_nxt     = in_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= 1'b0;
      smooth_r    <= RST_SMOOTHED;
      last_dng_r  <= '0;
      last_time_r <= '0;
      active_r    <= 1'b0;
      start_r     <= '0;
      item_vld_r  <= 1'b0;
      res_vld_r   <= 1'b0;
    end else begin
      seen_r      <= seen_nxt;
      smooth_r    <= smooth_nxt;
      last_dng_r  <= last_dng_nxt;
      last_time_r <= last_time_nxt;
      active_r    <= active_nxt;
      start_r     <= start_nxt;
      item_vld_r  <= item_vld_nxt;
      res_vld_r   <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

endmodule

// ===== hw/rtl/pah_checker.sv =====
// port-level checks for the proximity alarm top level, with its bind
module pah_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input pah_pkg::out_item_t out_data
);
  import pah_pkg::*;

  logic last_on_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_on_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      last_on_r <= out_data.alarm_on;
    end
  end

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // enter and clear messages alternate, starting with enter
  a_alternate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |-> out_data.alarm_on != last_on_r)
    else $error("alarm messages do not alternate");

  // an enter is never flagged as a timeout
  a_enter_no_timeout: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.alarm_on |-> !out_data.by_timeout)
    else $error("enter message flagged as timeout");

  // no result straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind proximity_alarm_hysteresis_top pah_checker u_pah_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

// ===== tb/tb_top.sv =====
// self-checking testbench for the proximity alarm block with a transaction-level alarm predictor
module tb_top;
  import pah_pkg::*;

  localparam int HOLD_OFF_CYCLES  = 400;
  localparam int WATCHDOG_LIMIT   = 5000;
  localparam int SETTLE_CYCLES    = 6;
  localparam int RANDOM_PER_PHASE = 120;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  class alarm_scoreboard;
    logic [7:0]        tracked;
    logic signed [7:0] enter_lvl;
    logic signed [7:0] exit_lvl;
    logic [31:0]       timeout_ms;
    logic [31:0]       hold_ms;
    logic [7:0]        danger_floor;
    logic [8:0]        weight;

    bit          seen;
    int          smoothed;
    logic [7:0]  danger_last;
    logic [31:0] beacon_ms;
    bit          active;
    logic [31:0] start_ms;

    out_item_t alarm_q[$];
    int        errors;
    int        changes_checked;

    function new();
      tracked      = RST_TRACKED_SOURCE;
      enter_lvl    = RST_ENTER_LEVEL;
      exit_lvl     = RST_EXIT_LEVEL;
      timeout_ms   = RST_BEACON_TIMEOUT;
      hold_ms      = RST_MIN_HOLD;
      danger_floor = RST_DANGER_MIN;
      weight       = RST_SMOOTHING_WEIGHT;
      seen         = 1'b0;
      smoothed     = int'(RST_SMOOTHED);
      danger_last  = 8'd0;
      beacon_ms    = 32'd0;
      active       = 1'b0;
      start_ms     = 32'd0;
      errors          = 0;
      changes_checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
      case (idx)
        CFG_TRACKED_SOURCE:   tracked      = value[7:0];
        CFG_ENTER_LEVEL:      enter_lvl    = value[7:0];
        CFG_EXIT_LEVEL:       exit_lvl     = value[7:0];
        CFG_BEACON_TIMEOUT:   timeout_ms   = value;
        CFG_MIN_HOLD:         hold_ms      = value;
        CFG_DANGER_MIN:       danger_floor = value[7:0];
        CFG_SMOOTHING_WEIGHT: weight       = value[8:0];
        default: ;
      endcase
    endfunction

    function void push_change(logic on, logic by_to);
      out_item_t msg;
      msg.alarm_on     = on;
      msg.alarm_source = tracked;
      msg.danger_out   = danger_last;
      msg.by_timeout   = by_to;
      alarm_q.push_back(msg);
    endfunction

    function void note_input(in_item_t it);
      int          w;
      int          acc;
      int          sample;
      logic [31:0] since_beacon;
      logic [31:0] since_start;
      bit          held;
      bit          dangerous;
      sample = int'($signed(it.strength)) * 256;
      if (it.operation == OP_BEACON) begin
        if (it.source_id != tracked) return;
        if (!seen) begin
          smoothed = sample;
          seen = 1'b1;
        end else begin
          w = (weight > WEIGHT_ONE) ? 256 : int'(weight);
          acc = w * sample + (256 - w) * smoothed;
          smoothed = acc >>> 8;
        end
        danger_last = it.danger_in;
        beacon_ms   = it.now_ms;
        return;
      end
      if (!seen) return;
      since_start  = it.now_ms - start_ms;
      since_beacon = it.now_ms - beacon_ms;
      held = (since_start >= hold_ms);
      if (since_beacon > timeout_ms) begin
        if (active && held) begin
          active = 1'b0;
          push_change(1'b0, 1'b1);
        end
        return;
      end
      dangerous = (danger_last >= danger_floor);
      if (!active) begin
        if (dangerous && smoothed >= int'(enter_lvl) * 256) begin
          active   = 1'b1;
          start_ms = it.now_ms;
          push_change(1'b1, 1'b0);
        end
      end else if (held && (smoothed <= int'(exit_lvl) * 256 || !dangerous)) begin
        active = 1'b0;
        push_change(1'b0, 1'b0);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (alarm_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected alarm transfer: on=%0b src=%0d danger=%0d timeout=%0b",
                   got.alarm_on, got.alarm_source, got.danger_out, got.by_timeout);
        return;
      end
      want = alarm_q.pop_front();
      changes_checked++;
      if (got.alarm_on !== want.alarm_on || got.alarm_source !== want.alarm_source ||
          got.danger_out !== want.danger_out || got.by_timeout !== want.by_timeout) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: expected on=%0b src=%0d danger=%0d timeout=%0b, ",
                    "got on=%0b src=%0d danger=%0d timeout=%0b"},
                   want.alarm_on, want.alarm_source, want.danger_out, want.by_timeout,
                   got.alarm_on, got.alarm_source, got.danger_out, got.by_timeout);
      end
    endfunction

    function int pending();
      return alarm_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  pah_in_if  in_bus ();
  pah_out_if out_bus ();
  pah_cfg_if cfg_bus ();

  proximity_alarm_hysteresis_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  alarm_scoreboard sb = new();

  int          burst_left = 0;
  int          items_sent = 0;
  int          settings_used = 0;
  logic [31:0] clock_ms = 32'd0;
  bit          hold_armed = 1'b0;
  int          rx_mode = 0;
  int          rx_left = 0;
  int          hold_cnt;
  int          idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) sb.note_input(in_bus.data);
      if (out_bus.valid && out_bus.ready) sb.check_result(out_bus.data);
      if (cfg_bus.valid && cfg_bus.ready) sb.write_reg(cfg_bus.data.index, cfg_bus.data.value);
    end
  end

  // receiver: own stall pattern, plus a long hold-off when armed
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed) begin
        hold_armed = 1'b0;
        out_bus.ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_OFF_CYCLES; hold_cnt++) @(posedge clk);
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(0, 2);
          rx_left = $urandom_range(10, 80);
        end
        rx_left--;
        case (rx_mode)
          0:       out_bus.ready <= 1'b1;
          1:       out_bus.ready <= 1'($urandom_range(0, 1));
          default: out_bus.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  function automatic in_item_t mk_item(logic op, logic [7:0] src, logic [7:0] dng,
                                       logic signed [7:0] str, logic [31:0] now);
    in_item_t it;
    it.operation = op;
    it.source_id = src;
    it.danger_in = dng;
    it.strength  = str;
    it.now_ms    = now;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                : $urandom_range(1, 40);
    end
    items_sent++;
    in_bus.data  <= it;
    in_bus.valid <= 1'b1;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    burst_left--;
    if (burst_left == 0) in_bus.valid <= 1'b0;
  endtask

  task automatic end_stream();
    if (burst_left != 0) begin
      in_bus.valid <= 1'b0;
      burst_left = 0;
    end
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_bus.data  <= '{index: idx, value: value};
    cfg_bus.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
  endtask

  task automatic apply_setting(input int p);
    int e;
    case (p)
      1: begin
        put_reg(CFG_TRACKED_SOURCE, 32'd7);
        put_reg(CFG_ENTER_LEVEL, -60);
        put_reg(CFG_EXIT_LEVEL, -75);
        put_reg(CFG_BEACON_TIMEOUT, 32'd2500);
        put_reg(CFG_MIN_HOLD, 32'd1500);
        put_reg(CFG_DANGER_MIN, 32'd3);
        put_reg(CFG_SMOOTHING_WEIGHT, 32'd100);
        put_reg(CFG_UNUSED_IDX, $urandom);
      end
      2: begin
        put_reg(CFG_TRACKED_SOURCE, 32'd0);
        put_reg(CFG_ENTER_LEVEL, -128);
        put_reg(CFG_EXIT_LEVEL, -128);
        put_reg(CFG_BEACON_TIMEOUT, 32'd0);
        put_reg(CFG_MIN_HOLD, 32'd0);
        put_reg(CFG_DANGER_MIN, 32'd0);
        put_reg(CFG_SMOOTHING_WEIGHT, 32'd0);
      end
      3: begin
        put_reg(CFG_TRACKED_SOURCE, 32'd255);
        put_reg(CFG_ENTER_LEVEL, 32'd127);
        put_reg(CFG_EXIT_LEVEL, 32'd127);
        put_reg(CFG_BEACON_TIMEOUT, 32'hFFFF_FFFF);
        put_reg(CFG_MIN_HOLD, 32'hFFFF_FFFF);
        put_reg(CFG_DANGER_MIN, 32'd255);
        put_reg(CFG_SMOOTHING_WEIGHT, 32'd511);
      end
      default: begin
        e = int'($urandom_range(0, 50)) - 90;
        put_reg(CFG_TRACKED_SOURCE, $urandom_range(0, 255));
        put_reg(CFG_ENTER_LEVEL, e);
        put_reg(CFG_EXIT_LEVEL, e - int'($urandom_range(0, 20)));
        put_reg(CFG_BEACON_TIMEOUT, $urandom_range(500, 6000));
        put_reg(CFG_MIN_HOLD, $urandom_range(0, 4000));
        put_reg(CFG_DANGER_MIN, $urandom_range(0, 8));
        put_reg(CFG_SMOOTHING_WEIGHT, (p == 4) ? $urandom_range(0, 300) : $urandom_range(0, 511));
        put_reg(CFG_UNUSED_IDX, $urandom);
      end
    endcase
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic send_random();
    in_item_t it;
    int       r;
    int       s;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      it.operation = 1'($urandom_range(0, 1));
      it.source_id = 8'($urandom);
      it.danger_in = 8'($urandom);
      it.strength  = 8'($urandom);
      it.now_ms    = $urandom;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 10)      clock_ms = clock_ms;
      else if (r < 65) clock_ms = clock_ms + $urandom_range(1, 400);
      else if (r < 95) clock_ms = clock_ms + $urandom_range(401, 5000);
      else             clock_ms = clock_ms + $urandom;
      it.now_ms    = clock_ms;
      it.operation = ($urandom_range(0, 99) < 55) ? OP_BEACON : OP_EVALUATE;
      it.source_id = ($urandom_range(0, 9) != 0) ? sb.tracked : 8'($urandom);
      s = int'(sb.enter_lvl) + int'($urandom_range(0, 40)) - 20;
      if (s > 127) s = 127;
      if (s < -128) s = -128;
      it.strength = ($urandom_range(0, 9) < 7) ? 8'(s) : 8'($urandom);
      case ($urandom_range(0, 3))
        0:       it.danger_in = 8'd0;
        1:       it.danger_in = 8'($urandom);
        default: it.danger_in = (sb.danger_floor > 8'd252) ? 8'd255
                                : sb.danger_floor + 8'($urandom_range(0, 3));
      endcase
    end
    send_item(it);
  endtask

  initial begin
    int p;
    int n;
    rst_n         <= 1'b0;
    in_bus.valid  <= 1'b0;
    in_bus.data   <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    settings_used = 1;

    // directed: before first beacon, untracked source, seeding, hold, far, timeout, wrap
    send_item(mk_item(OP_EVALUATE, 8'd2, 8'd255, 8'sd0, 32'd10));
    send_item(mk_item(OP_BEACON, 8'd5, 8'd255, 8'sd0, 32'd20));
    send_item(mk_item(OP_EVALUATE, 8'd2, 8'd0, 8'sd0, 32'd30));
    send_item(mk_item(OP_BEACON, 8'd2, 8'd255, 8'sd127, 32'd100));
    send_item(mk_item(OP_EVALUATE, 8'd0, 8'd0, 8'sd0, 32'd150));
    send_item(mk_item(OP_EVALUATE, 8'd0, 8'd0, 8'sd0, 32'd500));
    send_item(mk_item(OP_BEACON, 8'd2, 8'd0, -8'sd128, 32'd600));
    send_item(mk_item(OP_EVALUATE, 8'd0, 8'd0, 8'sd0, 32'd1000));
    send_item(mk_item(OP_EVALUATE, 8'd0, 8'd0, 8'sd0, 32'd2200));
    send_item(mk_item(OP_BEACON, 8'd2, 8'd255, 8'sd127, 32'd2300));
    send_item(mk_item(OP_EVALUATE, 8'd0, 8'd0, 8'sd0, 32'd2400));
    send_item(mk_item(OP_EVALUATE, 8'd0, 8'd0, 8'sd0, 32'd6000));
    send_item(mk_item(OP_EVALUATE, 8'd0, 8'd0, 8'sd0, 32'd7000));
    send_item(mk_item(OP_BEACON, 8'd2, 8'd1, -8'sd70, 32'hFFFF_FF00));
    send_item(mk_item(OP_EVALUATE, 8'd255, 8'd255, 8'sd127, 32'h0000_0010));
    send_item(mk_item(OP_BEACON, 8'd0, 8'd255, 8'sd127, 32'h0000_0020));
    send_item(mk_item(OP_BEACON, 8'd255, 8'd255, 8'sd127, 32'h0000_0030));
    send_item(mk_item(OP_BEACON, 8'd2, 8'd255, 8'sd127, 32'hFFFF_FFFF));
    send_item(mk_item(OP_EVALUATE, 8'd0, 8'd0, 8'sd0, 32'h0000_0000));
    send_item(mk_item(OP_EVALUATE, 8'd0, 8'd0, 8'sd0, 32'h0000_1000));
    send_item(mk_item(OP_EVALUATE, 8'd0, 8'd0, 8'sd0, 32'h7FFF_FFFF));
    end_stream();
    wait_idle();

    for (p = 1; p <= 5; p++) begin
      apply_setting(p);
      settings_used++;
      wait_idle();
      hold_armed = (p == 1 || p == 4);
      n = 0;
      while (n < RANDOM_PER_PHASE) begin
        send_random();
        n++;
      end
      end_stream();
      wait_idle();
    end

    $display("%0d items under %0d register settings, %0d alarm transitions checked",
             items_sent, settings_used, sb.changes_checked);
    $display("%0d mismatches", sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      if (sb.pending() != 0) $display("%0d expected transitions never arrived", sb.pending());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/pah_pkg.sv
hw/rtl/pah_if.sv
hw/rtl/proximity_alarm_hysteresis_top.sv
hw/rtl/pah_checker.sv
tb/tb_top.sv
